/* src/pcode_stack_machine_core_top_assert.svh */
// Assertion macros shared by the stack machine core.
`ifndef PCODE_STACK_MACHINE_CORE_TOP_ASSERT_SVH
`define PCODE_STACK_MACHINE_CORE_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PCSM_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define PCSM_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCSM_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg)
`define PCSM_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg)
`endif

`endif

/* src/pcsm_pkg.sv */
// Shared types and constants of the p-code stack machine core.
package pcsm_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int TOP_W       = ADDR_W + 1;
    localparam int PC_W        = 11;
    localparam int OPD_W       = 11;
    localparam int LEV_W       = 2;
    localparam int FC_W        = 3;

    typedef enum logic [FC_W-1:0] {
        OP_LIT = 3'd0,
        OP_OPR = 3'd1,
        OP_LOD = 3'd2,
        OP_STO = 3'd3,
        OP_CAL = 3'd4,
        OP_INT = 3'd5,
        OP_JMP = 3'd6,
        OP_JPC = 3'd7
    } op_t;

    // Operator codes carried in the operand of OPR.
    localparam logic [OPD_W-1:0] OPR_RET = 11'd0;
    localparam logic [OPD_W-1:0] OPR_NEG = 11'd1;
    localparam logic [OPD_W-1:0] OPR_ADD = 11'd2;
    localparam logic [OPD_W-1:0] OPR_SUB = 11'd3;
    localparam logic [OPD_W-1:0] OPR_MUL = 11'd4;
    localparam logic [OPD_W-1:0] OPR_DIV = 11'd5;
    localparam logic [OPD_W-1:0] OPR_ODD = 11'd6;
    localparam logic [OPD_W-1:0] OPR_EQ  = 11'd8;
    localparam logic [OPD_W-1:0] OPR_NE  = 11'd9;
    localparam logic [OPD_W-1:0] OPR_LT  = 11'd10;
    localparam logic [OPD_W-1:0] OPR_GE  = 11'd11;
    localparam logic [OPD_W-1:0] OPR_GT  = 11'd12;
    localparam logic [OPD_W-1:0] OPR_LE  = 11'd13;

    typedef enum logic [1:0] {
        OC_RET,
        OC_UNARY,
        OC_BINARY,
        OC_NOP
    } opr_cls_t;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_DIV   = 2'd1,
        FAULT_RANGE = 2'd2
    } fault_t;

    typedef struct packed {
        op_t              fc;
        logic [LEV_W-1:0] lev;
        logic [OPD_W-1:0] opd;
        opr_cls_t         cls;
        logic             walk;
    } instr_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } back_status_t;

endpackage

/* src/pcode_stack_machine_core_top.sv */
// Top level of the PL/0 p-code stack machine execution core.
// This core executes one fetched p-code instruction per input transfer and
// returns one result transfer per instruction carrying the program counter,
// top index, frame base, top-of-stack word, a halted flag and a fault code.
// After reset the core first clears its 4096-word data stack, one word per
// cycle, before the sequencer takes its first instruction; instructions are
// still taken into the input queue meanwhile, until it is full.
// A two-entry queue separates the decoding front end from the sequencer, so
// the input side keeps accepting while a result waits at the output register.
// The sequencer takes an instruction from the queue, walks the static links
// for LOD, STO and CAL, reads operands from the stack as needed, computes and
// writes back, and then registers the result. Divide uses the bit-serial
// divider; a zero divisor is found before the divider starts. The stack
// memory has one write and one read per cycle and registered read data.
// The next instruction enters the sequencer only in the cycle after the
// previous result has been taken by the output side.
// A faulting instruction leaves all state as it was and reports divide by
// zero or a stack index out of range.
`include "pcode_stack_machine_core_top_assert.svh"

module pcode_stack_machine_core_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pcsm_pkg::FC_W-1:0]          function_code,
    input  logic [pcsm_pkg::LEV_W-1:0]         level,
    input  logic [pcsm_pkg::OPD_W-1:0]         operand,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pcsm_pkg::PC_W-1:0]          next_pc,
    output logic signed [pcsm_pkg::TOP_W-1:0]  top_index,
    output logic [pcsm_pkg::ADDR_W-1:0]        frame_base,
    output logic signed [pcsm_pkg::DATA_W-1:0] top_value,
    output logic                               halted,
    output logic [1:0]                         fault
);
    import pcsm_pkg::*;

    // Link between the front end queue and the execution sequencer.
    logic         q_valid;
    instr_t       q_item;
    logic         pop;
    back_status_t status;

    pcsm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .function_code (function_code),
        .level         (level),
        .operand       (operand),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop)
    );

    pcsm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .next_pc    (next_pc),
        .top_index  (top_index),
        .frame_base (frame_base),
        .top_value  (top_value),
        .halted     (halted),
        .fault      (fault)
    );

    // No instruction may leave the queue while the stack is being cleared.
    `PCSM_ASSERT_IMP(a_no_pop_in_clear, clk, rst_n, status.clearing, !pop, "pop during clear")
    // A pop only happens when the queue holds an instruction and the sequencer is free.
    `PCSM_ASSERT_IMP(a_pop_needs_item, clk, rst_n, pop, q_valid && !out_valid && !status.busy, "bad pop")
    // The halted flag always agrees with the reported program counter.
    `PCSM_ASSERT_IMP(a_halt_match, clk, rst_n, out_valid, halted == (next_pc == '0), "halted mismatch")
    // The top index never reports anything below the empty mark, and fault code three never appears.
    `PCSM_ASSERT_IMP(a_out_range, clk, rst_n, out_valid, (!top_index[TOP_W-1] || top_index == '1) && fault != 2'd3, "result out of range")
    // After a pop the sequencer is busy on the next cycle.
    `PCSM_ASSERT_NXT(a_busy_after_pop, clk, rst_n, pop, status.busy, "sequencer idle after pop")

endmodule

/* src/pcsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/pcsm_front.sv */
// Front end: accepts instructions, classifies them and queues them for execution.
module pcsm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pcsm_pkg::FC_W-1:0]   function_code,
    input  logic [pcsm_pkg::LEV_W-1:0]  level,
    input  logic [pcsm_pkg::OPD_W-1:0]  operand,
    output logic                        q_valid,
    output pcsm_pkg::instr_t            q_item,
    input  logic                        pop
);
    import pcsm_pkg::*;

    instr_t      entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    instr_t      decoded;
    logic        push;

    always_comb
    begin
        decoded.fc   = op_t'(function_code);
        decoded.lev  = level;
        decoded.opd  = operand;
        decoded.walk = 1'b0;
        unique case (operand) inside
            OPR_RET:                            decoded.cls = OC_RET;
            OPR_NEG, OPR_ODD:                   decoded.cls = OC_UNARY;
            [OPR_ADD:OPR_DIV], [OPR_EQ:OPR_LE]: decoded.cls = OC_BINARY;
            default:                            decoded.cls = OC_NOP;
        endcase
        unique case (decoded.fc) inside
            OP_LOD, OP_STO, OP_CAL: decoded.walk = 1'b1;
            default:                decoded.walk = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

/* src/pcsm_div.sv */
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module pcsm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pcsm_pkg::DATA_W-1:0] dividend,
    input  logic [pcsm_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [pcsm_pkg::DATA_W-1:0] quotient
);
    import pcsm_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              active_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [DATA_W:0]   rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] mb_reg;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign trial    = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
    assign fits     = (trial >= {1'b0, mb_reg});
    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(DATA_W);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            mb_reg  <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (active_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, mb_reg}) : trial;
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

endmodule

/* src/pcsm_back.sv */
// Back end: sequencer that executes one queued instruction against the stack memory.
module pcsm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  pcsm_pkg::instr_t                  q_item,
    output logic                              pop,
    output pcsm_pkg::back_status_t            status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pcsm_pkg::PC_W-1:0]         next_pc,
    output logic signed [pcsm_pkg::TOP_W-1:0] top_index,
    output logic [pcsm_pkg::ADDR_W-1:0]       frame_base,
    output logic signed [pcsm_pkg::DATA_W-1:0] top_value,
    output logic                              halted,
    output logic [1:0]                        fault
);
    import pcsm_pkg::*;

    localparam int CHK_W = TOP_W + 2;
    localparam logic signed [CHK_W-1:0] DEPTH_S = CHK_W'(STACK_DEPTH);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_WALK  = 14'b00000000000100,
        S_WLAT  = 14'b00000000001000,
        S_EXEC  = 14'b00000000010000,
        S_RD1   = 14'b00000000100000,
        S_RD2   = 14'b00000001000000,
        S_ALU   = 14'b00000010000000,
        S_DIV   = 14'b00000100000000,
        S_WB    = 14'b00001000000000,
        S_CAL2  = 14'b00010000000000,
        S_CAL3  = 14'b00100000000000,
        S_FIN   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [ADDR_W-1:0]        clr_reg, clr_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic [ADDR_W-1:0]        b_reg, b_next;
    logic signed [TOP_W-1:0]  t_reg, t_next;
    logic                     ovalid_reg, ovalid_next;

    instr_t                   item_reg, item_next;
    logic [LEV_W-1:0]         lvl_reg, lvl_next;
    logic [DATA_W-1:0]        walk_reg, walk_next;
    logic [PC_W-1:0]          p_reg, p_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic [DATA_W-1:0]        x_reg, x_next;
    logic [DATA_W-1:0]        y_reg, y_next;
    logic [DATA_W-1:0]        r_reg, r_next;
    fault_t                   fault_reg, fault_next;

    logic [PC_W-1:0]          onpc_reg, onpc_next;
    logic [TOP_W-1:0]         otop_reg, otop_next;
    logic [ADDR_W-1:0]        obase_reg, obase_next;
    logic [DATA_W-1:0]        oval_reg, oval_next;
    logic                     ohalt_reg, ohalt_next;
    fault_t                   ofault_reg, ofault_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        rdata;

    logic                     div_start;
    logic                     div_done;
    logic [DATA_W-1:0]        div_q;
    // Registers whether the state is S_DIV, so the divider starts only once per divide.
    logic                     div_busy_reg;

    logic signed [CHK_W-1:0]  tx;
    logic signed [CHK_W-1:0]  t_int;
    logic [TOP_W-1:0]         t_p1, t_p2, t_p3, t_m1;
    logic [ADDR_W-1:0]        t_idx;
    logic                     t_ge0, t_ge1;
    logic                     push_ok, cal_ok, int_ok, ret_ok;
    logic                     walk_idx_ok, frame_ok;
    logic [ADDR_W:0]          frame_sum;
    logic [ADDR_W:0]          ret_sum;
    logic [DATA_W-1:0]        alu_r;

    pcsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    pcsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  (y_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Range checks are done in a few extra bits so that nothing wraps.
    assign tx          = CHK_W'(t_reg);
    assign t_int       = tx + CHK_W'({1'b0, item_reg.opd});
    assign t_p1        = t_reg + TOP_W'(1);
    assign t_p2        = t_reg + TOP_W'(2);
    assign t_p3        = t_reg + TOP_W'(3);
    assign t_m1        = t_reg - TOP_W'(1);
    assign t_idx       = t_reg[ADDR_W-1:0];
    assign t_ge0       = !t_reg[TOP_W-1];
    assign t_ge1       = t_ge0 && (t_reg != '0);
    assign push_ok     = (tx + CHK_W'(1)) < DEPTH_S;
    assign cal_ok      = (tx + CHK_W'(3)) < DEPTH_S;
    assign int_ok      = t_int < DEPTH_S;
    assign ret_sum     = {1'b0, b_reg} + (ADDR_W+1)'(2);
    assign ret_ok      = !ret_sum[ADDR_W];
    assign walk_idx_ok = (walk_reg[DATA_W-1:ADDR_W] == '0);
    assign frame_sum   = {1'b0, walk_reg[ADDR_W-1:0]} + (ADDR_W+1)'(item_reg.opd);
    assign frame_ok    = walk_idx_ok && !frame_sum[ADDR_W];

    always_comb
    begin
        case (item_reg.opd)
            OPR_ADD: alu_r = x_reg + y_reg;
            OPR_SUB: alu_r = x_reg - y_reg;
            OPR_MUL: alu_r = DATA_W'(x_reg * y_reg);
            OPR_EQ:  alu_r = DATA_W'(x_reg == y_reg);
            OPR_NE:  alu_r = DATA_W'(x_reg != y_reg);
            OPR_LT:  alu_r = DATA_W'($signed(x_reg) <  $signed(y_reg));
            OPR_GE:  alu_r = DATA_W'($signed(x_reg) >= $signed(y_reg));
            OPR_GT:  alu_r = DATA_W'($signed(x_reg) >  $signed(y_reg));
            OPR_LE:  alu_r = DATA_W'($signed(x_reg) <= $signed(y_reg));
            default: alu_r = '0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pc_next     = pc_reg;
        b_next      = b_reg;
        t_next      = t_reg;
        ovalid_next = ovalid_reg;
        item_next   = item_reg;
        lvl_next    = lvl_reg;
        walk_next   = walk_reg;
        p_next      = p_reg;
        addr_next   = addr_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        r_next      = r_reg;
        fault_next  = fault_reg;
        onpc_next   = onpc_reg;
        otop_next   = otop_reg;
        obase_next  = obase_reg;
        oval_next   = oval_reg;
        ohalt_next  = ohalt_reg;
        ofault_next = ofault_reg;
        ram_we      = 1'b0;
        ram_waddr   = t_p1[ADDR_W-1:0];
        ram_wdata   = '0;
        ram_raddr   = t_idx;
        pop         = 1'b0;
        div_start   = 1'b0;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && !ovalid_reg)
                begin
                    pop        = 1'b1;
                    item_next  = q_item;
                    lvl_next   = q_item.walk ? q_item.lev : '0;
                    walk_next  = DATA_W'(b_reg);
                    p_next     = pc_reg + 1'b1;
                    fault_next = FAULT_NONE;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = S_EXEC;
                end
                else if (!walk_idx_ok)
                begin
                    fault_next = FAULT_RANGE;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_raddr  = walk_reg[ADDR_W-1:0];
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_WLAT;
                end
            end
            S_WLAT:
            begin
                walk_next  = rdata;
                state_next = S_WALK;
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                unique case (item_reg.fc)
                    OP_LIT:
                    begin
                        if (push_ok)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = DATA_W'(item_reg.opd);
                            t_next    = t_p1;
                        end
                        else
                        begin
                            fault_next = FAULT_RANGE;
                        end
                    end
                    OP_OPR:
                    begin
                        unique case (item_reg.cls)
                            OC_RET:
                            begin
                                if (ret_ok)
                                begin
                                    ram_raddr  = b_reg + 1'b1;
                                    state_next = S_RD1;
                                end
                                else
                                begin
                                    fault_next = FAULT_RANGE;
                                end
                            end
                            OC_UNARY:
                            begin
                                if (t_ge0)
                                begin
                                    state_next = S_RD1;
                                end
                                else
                                begin
                                    fault_next = FAULT_RANGE;
                                end
                            end
                            OC_BINARY:
                            begin
                                if (t_ge1)
                                begin
                                    ram_raddr  = t_m1[ADDR_W-1:0];
                                    state_next = S_RD1;
                                end
                                else
                                begin
                                    fault_next = FAULT_RANGE;
                                end
                            end
                            default:
                            begin
                                state_next = S_FIN;
                            end
                        endcase
                    end
                    OP_LOD:
                    begin
                        if (push_ok && frame_ok)
                        begin
                            ram_raddr  = frame_sum[ADDR_W-1:0];
                            state_next = S_RD1;
                        end
                        else
                        begin
                            fault_next = FAULT_RANGE;
                        end
                    end
                    OP_STO:
                    begin
                        if (t_ge0 && frame_ok)
                        begin
                            addr_next  = frame_sum[ADDR_W-1:0];
                            state_next = S_RD1;
                        end
                        else
                        begin
                            fault_next = FAULT_RANGE;
                        end
                    end
                    OP_CAL:
                    begin
                        if (cal_ok)
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = walk_reg;
                            state_next = S_CAL2;
                        end
                        else
                        begin
                            fault_next = FAULT_RANGE;
                        end
                    end
                    OP_INT:
                    begin
                        if (int_ok)
                        begin
                            t_next = t_int[TOP_W-1:0];
                        end
                        else
                        begin
                            fault_next = FAULT_RANGE;
                        end
                    end
                    OP_JMP:
                    begin
                        p_next = item_reg.opd;
                    end
                    OP_JPC:
                    begin
                        if (t_ge0)
                        begin
                            state_next = S_RD1;
                        end
                        else
                        begin
                            fault_next = FAULT_RANGE;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RD1:
            begin
                state_next = S_FIN;
                case (item_reg.fc)
                    OP_OPR:
                    begin
                        case (item_reg.cls)
                            OC_RET:
                            begin
                                x_next     = rdata;
                                ram_raddr  = ret_sum[ADDR_W-1:0];
                                state_next = S_RD2;
                            end
                            OC_UNARY:
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = t_idx;
                                ram_wdata = (item_reg.opd == OPR_NEG) ? (~rdata + 1'b1)
                                                                      : DATA_W'(rdata[0]);
                            end
                            OC_BINARY:
                            begin
                                x_next     = rdata;
                                state_next = S_RD2;
                            end
                            default:
                            begin
                                state_next = S_FIN;
                            end
                        endcase
                    end
                    OP_LOD:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = rdata;
                        t_next    = t_p1;
                    end
                    OP_STO:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = addr_reg;
                        ram_wdata = rdata;
                        t_next    = t_m1;
                    end
                    OP_JPC:
                    begin
                        if (rdata != '0)
                        begin
                            p_next = item_reg.opd;
                        end
                        t_next = t_m1;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RD2:
            begin
                if (item_reg.cls == OC_RET)
                begin
                    state_next = S_FIN;
                    if (x_reg[DATA_W-1:ADDR_W] == '0)
                    begin
                        t_next = $signed({1'b0, b_reg}) - TOP_W'(1);
                        p_next = rdata[PC_W-1:0];
                        b_next = x_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        fault_next = FAULT_RANGE;
                    end
                end
                else
                begin
                    y_next = rdata;
                    if (item_reg.opd == OPR_DIV)
                    begin
                        if (rdata == '0)
                        begin
                            fault_next = FAULT_DIV;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        state_next = S_ALU;
                    end
                end
            end
            S_ALU:
            begin
                r_next     = alu_r;
                state_next = S_WB;
            end
            S_DIV:
            begin
                // The divider starts here, on entry, with both operands already held in registers.
                div_start = !div_busy_reg;
                if (div_done)
                begin
                    r_next     = div_q;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = t_m1[ADDR_W-1:0];
                ram_wdata  = r_reg;
                t_next     = t_m1;
                state_next = S_FIN;
            end
            S_CAL2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = t_p2[ADDR_W-1:0];
                ram_wdata  = DATA_W'(b_reg);
                state_next = S_CAL3;
            end
            S_CAL3:
            begin
                ram_we     = 1'b1;
                ram_waddr  = t_p3[ADDR_W-1:0];
                ram_wdata  = DATA_W'(p_reg);
                b_next     = t_p1[ADDR_W-1:0];
                p_next     = item_reg.opd;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fault_reg == FAULT_NONE)
                begin
                    pc_next = p_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                onpc_next   = pc_reg;
                otop_next   = t_reg;
                obase_next  = b_reg;
                oval_next   = t_ge0 ? rdata : '0;
                ohalt_next  = (pc_reg == '0);
                ofault_next = fault_reg;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
        end
        else
        begin
            div_busy_reg <= (state_reg == S_DIV);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            pc_reg     <= '0;
            b_reg      <= '0;
            t_reg      <= '1;
            ovalid_reg <= 1'b0;
            fault_reg  <= FAULT_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pc_reg     <= pc_next;
            b_reg      <= b_next;
            t_reg      <= t_next;
            ovalid_reg <= ovalid_next;
            fault_reg  <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        lvl_reg    <= lvl_next;
        walk_reg   <= walk_next;
        p_reg      <= p_next;
        addr_reg   <= addr_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        r_reg      <= r_next;
        onpc_reg   <= onpc_next;
        otop_reg   <= otop_next;
        obase_reg  <= obase_next;
        oval_reg   <= oval_next;
        ohalt_reg  <= ohalt_next;
        ofault_reg <= ofault_next;
    end

    assign status.clearing = (state_reg == S_CLEAR);
    assign status.busy     = (state_reg != S_IDLE) && (state_reg != S_CLEAR);

    assign out_valid  = ovalid_reg;
    assign next_pc    = onpc_reg;
    assign top_index  = otop_reg;
    assign frame_base = obase_reg;
    assign top_value  = oval_reg;
    assign halted     = ohalt_reg;
    assign fault      = ofault_reg;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the p-code stack machine execution core.
`timescale 1ns / 1ps

module tb;
    import pcsm_pkg::*;

    // One fetched instruction as the sender offers it. A sync item is held
    // back until every result of earlier instructions has come out.
    typedef struct {
        op_t              fc;
        logic [LEV_W-1:0] lev;
        logic [OPD_W-1:0] opd;
        bit               sync;
    } tb_instr_t;

    // Machine state the core should report after one instruction.
    typedef struct {
        logic [PC_W-1:0]          pc;
        logic signed [TOP_W-1:0]  top;
        logic [ADDR_W-1:0]        base;
        logic signed [DATA_W-1:0] word;
        logic                     halt;
        fault_t                   flt;
    } tb_state_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [FC_W-1:0]           function_code;
    logic [LEV_W-1:0]          level;
    logic [OPD_W-1:0]          operand;
    logic                      out_valid;
    logic                      out_ready;
    logic [PC_W-1:0]           next_pc;
    logic signed [TOP_W-1:0]   top_index;
    logic [ADDR_W-1:0]         frame_base;
    logic signed [DATA_W-1:0]  top_value;
    logic                      halted;
    logic [1:0]                fault;

    pcode_stack_machine_core_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .function_code (function_code),
        .level         (level),
        .operand       (operand),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .next_pc       (next_pc),
        .top_index     (top_index),
        .frame_base    (frame_base),
        .top_value     (top_value),
        .halted        (halted),
        .fault         (fault)
    );

    // Shadow copy of the machine that the checker keeps in step with the
    // core: the data stack, the program counter, the frame base and the top.
    logic [DATA_W-1:0] mach_stack [STACK_DEPTH];
    logic [PC_W-1:0]   mach_pc;
    logic [ADDR_W-1:0] mach_base;
    longint            mach_top;

    tb_instr_t program_q[$];   // instructions not yet offered to the core
    tb_state_t state_q[$];     // predicted states, oldest first
    tb_instr_t offered;        // instruction currently held on the input port

    int send_gap;
    int recv_hold;
    bit burst_mode;
    bit long_hold_done;
    int n_sent;
    int n_checked;
    int n_errors;
    int n_div_faults;
    int n_range_faults;
    int n_halts;

    // Follows the static links from the current frame base down lev levels.
    task automatic follow_links(input int lev, output bit ok, output logic [DATA_W-1:0] link);
        link = {{(DATA_W-ADDR_W){1'b0}}, mach_base};
        ok   = 1'b1;
        for (int i = 0; i < lev; i++)
        begin
            if (link >= STACK_DEPTH)
            begin
                ok = 1'b0;
                return;
            end
            link = mach_stack[link[ADDR_W-1:0]];
        end
    endtask

    // Stack address of a variable at the given level and frame offset.
    task automatic frame_slot(input int lev, input logic [OPD_W-1:0] off,
                              output bit ok, output int slot);
        logic [DATA_W-1:0] link;
        follow_links(lev, ok, link);
        slot = 0;
        if (ok && link < STACK_DEPTH && longint'(link) + off < STACK_DEPTH)
            slot = int'(link) + off;
        else
            ok = 1'b0;
    endtask

    // Executes one instruction on the shadow machine and returns the state
    // the core must report for it. A faulting instruction changes nothing.
    task automatic execute_instr(input tb_instr_t it, output tb_state_t res);
        longint            t;
        logic [PC_W-1:0]   p;
        logic [ADDR_W-1:0] b;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] mx;
        logic [DATA_W-1:0] my;
        logic [DATA_W-1:0] link;
        fault_t            f;
        bit                ok;
        int                slot;
        t = mach_top;
        p = mach_pc + 1'b1;
        b = mach_base;
        f = FAULT_NONE;
        r = '0;
        case (it.fc)
            OP_LIT:
                if (t + 1 >= STACK_DEPTH)
                    f = FAULT_RANGE;
                else
                begin
                    t++;
                    mach_stack[t] = DATA_W'(it.opd);
                end
            OP_OPR:
                if (it.opd == OPR_RET)
                begin
                    if (int'(b) + 2 >= STACK_DEPTH || mach_stack[b + 1] >= STACK_DEPTH)
                        f = FAULT_RANGE;
                    else
                    begin
                        t = longint'(b) - 1;
                        p = mach_stack[b + 2][PC_W-1:0];
                        b = mach_stack[b + 1][ADDR_W-1:0];
                    end
                end
                else if (it.opd == OPR_NEG || it.opd == OPR_ODD)
                begin
                    if (t < 0)
                        f = FAULT_RANGE;
                    else if (it.opd == OPR_NEG)
                        mach_stack[t] = -mach_stack[t];
                    else
                        mach_stack[t] = DATA_W'(mach_stack[t][0]);
                end
                else if ((it.opd >= OPR_ADD && it.opd <= OPR_DIV) ||
                         (it.opd >= OPR_EQ && it.opd <= OPR_LE))
                begin
                    if (t < 1)
                        f = FAULT_RANGE;
                    else
                    begin
                        x = mach_stack[t - 1];
                        y = mach_stack[t];
                        case (it.opd)
                            OPR_ADD: r = x + y;
                            OPR_SUB: r = x - y;
                            OPR_MUL: r = x * y;
                            OPR_DIV:
                                if (y == 0)
                                    f = FAULT_DIV;
                                else
                                begin
                                    // Divide magnitudes and fix the sign, so that
                                    // the most negative word over minus one wraps.
                                    mx = x[DATA_W-1] ? -x : x;
                                    my = y[DATA_W-1] ? -y : y;
                                    r  = mx / my;
                                    if (x[DATA_W-1] != y[DATA_W-1])
                                        r = -r;
                                end
                            OPR_EQ:  r = DATA_W'(x == y);
                            OPR_NE:  r = DATA_W'(x != y);
                            OPR_LT:  r = DATA_W'($signed(x) < $signed(y));
                            OPR_GE:  r = DATA_W'($signed(x) >= $signed(y));
                            OPR_GT:  r = DATA_W'($signed(x) > $signed(y));
                            default: r = DATA_W'($signed(x) <= $signed(y));
                        endcase
                        if (f == FAULT_NONE)
                        begin
                            t--;
                            mach_stack[t] = r;
                        end
                    end
                end
            OP_LOD:
            begin
                frame_slot(it.lev, it.opd, ok, slot);
                if (t + 1 >= STACK_DEPTH || !ok)
                    f = FAULT_RANGE;
                else
                begin
                    t++;
                    mach_stack[t] = mach_stack[slot];
                end
            end
            OP_STO:
            begin
                frame_slot(it.lev, it.opd, ok, slot);
                if (t < 0 || !ok)
                    f = FAULT_RANGE;
                else
                begin
                    mach_stack[slot] = mach_stack[t];
                    t--;
                end
            end
            OP_CAL:
            begin
                follow_links(it.lev, ok, link);
                if (t + 3 >= STACK_DEPTH || !ok)
                    f = FAULT_RANGE;
                else
                begin
                    mach_stack[t + 1] = link;
                    mach_stack[t + 2] = DATA_W'(b);
                    mach_stack[t + 3] = DATA_W'(p);
                    b = ADDR_W'(t + 1);
                    p = it.opd;
                end
            end
            OP_INT:
                // The offset is zero-extended into a signed longint, so that an empty
                // stack plus zero stays at minus one.
                if (t + longint'(it.opd) >= STACK_DEPTH)
                    f = FAULT_RANGE;
                else
                    t += longint'(it.opd);
            OP_JMP:
                p = it.opd;
            default:
                if (t < 0)
                    f = FAULT_RANGE;
                else
                begin
                    if (mach_stack[t] != 0)
                        p = it.opd;
                    t--;
                end
        endcase
        if (f == FAULT_NONE)
        begin
            mach_pc   = p;
            mach_base = b;
            mach_top  = t;
        end
        res.pc   = mach_pc;
        res.top  = TOP_W'(mach_top);
        res.base = mach_base;
        res.word = (mach_top >= 0) ? mach_stack[mach_top] : '0;
        res.halt = (mach_pc == 0);
        res.flt  = f;
    endtask

    function automatic void add_instr(input op_t fc, input int lev, input int opd,
                                      input bit sync = 0);
        tb_instr_t it;
        it.fc   = fc;
        it.lev  = LEV_W'(lev);
        it.opd  = OPD_W'(opd);
        it.sync = sync;
        program_q.push_back(it);
    endfunction

    function automatic int pick_operator();
        int k;
        k = $urandom_range(0, 15);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 2047);
        return k;
    endfunction

    // Appends a short random sequence and returns how many instructions
    // it held. Most sequences are well formed; the rest are plain noise.
    function automatic int add_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        n = 0;
        if (kind <= 2)
        begin
            // Expression: two literals and a random operator, which may also be a return or an unknown code.
            add_instr(OP_LIT, $urandom_range(0, 3), $urandom_range(0, 2047));
            add_instr(OP_LIT, $urandom_range(0, 3), $urandom_range(0, 2047));
            add_instr(OP_OPR, $urandom_range(0, 3), pick_operator());
            n = 3;
        end
        else if (kind <= 4)
        begin
            // Procedure frame: call, allocate, store and load locals, apply an operator, branch, return.
            add_instr(OP_CAL, $urandom_range(0, 3), $urandom_range(0, 2047));
            add_instr(OP_INT, 0, $urandom_range(3, 8));
            add_instr(OP_LIT, 0, $urandom_range(0, 2047));
            add_instr(OP_STO, 0, 3);
            add_instr(OP_LOD, $urandom_range(0, 3), $urandom_range(0, 5));
            add_instr(OP_LOD, 0, 3);
            add_instr(OP_OPR, 0, pick_operator());
            add_instr(OP_JPC, 0, $urandom_range(0, 2047));
            add_instr(OP_OPR, 0, OPR_RET);
            n = 9;
        end
        else if (kind <= 8)
        begin
            case ($urandom_range(0, 7))
                0, 1: add_instr(OP_LIT, $urandom_range(0, 3), $urandom_range(0, 2047));
                2, 3: add_instr(OP_OPR, $urandom_range(0, 3), pick_operator());
                4:    add_instr(OP_LOD, $urandom_range(0, 3),
                                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                            : $urandom_range(0, 15));
                5:    add_instr(OP_STO, $urandom_range(0, 3),
                                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                            : $urandom_range(0, 15));
                6:    add_instr(OP_INT, $urandom_range(0, 3),
                                ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                                             : $urandom_range(0, 8));
                default: add_instr(($urandom_range(0, 1) == 1) ? OP_JMP : OP_JPC,
                                   $urandom_range(0, 3), $urandom_range(0, 2047));
            endcase
            n = 1;
        end
        else
        begin
            add_instr(op_t'($urandom_range(0, 7)), $urandom_range(0, 3), $urandom_range(0, 2047));
            n = 1;
        end
        return n;
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 15);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Driver: offers queued instructions with random gaps or, in burst mode, back to back. Each transfer is
    // executed on the shadow machine at the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        tb_state_t predicted;
        bit        waiting;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            function_code <= '0;
            level         <= '0;
            operand       <= '0;
            send_gap      = 0;
        end
        else
        begin
            waiting = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                execute_instr(offered, predicted);
                state_q.push_back(predicted);
                n_sent++;
                // Switch between bursts without idling and random gaps.
                if (n_sent % 150 == 0)
                    burst_mode = ~burst_mode;
            end
            if (!waiting)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (program_q.size() > 0 &&
                         !(program_q[0].sync && (state_q.size() > 0 || in_valid)))
                begin
                    offered = program_q.pop_front();
                    function_code <= offered.fc;
                    level         <= offered.lev;
                    operand       <= offered.opd;
                    in_valid      <= 1'b1;
                    send_gap      = draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: takes results with random stalls and compares each one with
    // the oldest prediction. Once, the receiver holds off for a long stretch
    // so that the core backs up and stops taking instructions.
    always @(posedge clk or negedge rst_n)
    begin
        tb_state_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (state_q.size() == 0)
                begin
                    $error("result transfer with no instruction outstanding");
                    n_errors++;
                end
                else
                begin
                    want = state_q.pop_front();
                    n_checked++;
                    if (next_pc !== want.pc)
                    begin
                        $error("next_pc: expected %0d, got %0d", want.pc, next_pc);
                        n_errors++;
                    end
                    if (top_index !== want.top)
                    begin
                        $error("top_index: expected %0d, got %0d", want.top, top_index);
                        n_errors++;
                    end
                    if (frame_base !== want.base)
                    begin
                        $error("frame_base: expected %0d, got %0d", want.base, frame_base);
                        n_errors++;
                    end
                    if (top_value !== want.word)
                    begin
                        $error("top_value: expected %0d, got %0d", want.word, top_value);
                        n_errors++;
                    end
                    if (halted !== want.halt)
                    begin
                        $error("halted: expected %0d, got %0d", want.halt, halted);
                        n_errors++;
                    end
                    if (fault !== want.flt)
                    begin
                        $error("fault: expected %0d, got %0d", want.flt, fault);
                        n_errors++;
                    end
                    if (want.flt == FAULT_DIV)
                        n_div_faults++;
                    if (want.flt == FAULT_RANGE)
                        n_range_faults++;
                    if (want.halt)
                        n_halts++;
                end
                if (n_checked == 300 && !long_hold_done)
                begin
                    recv_hold = 600;
                    long_hold_done = 1'b1;
                end
                else
                    recv_hold = draw_gap();
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int total;
        foreach (mach_stack[i])
            mach_stack[i] = '0;
        mach_pc        = '0;
        mach_base      = '0;
        mach_top       = -1;
        burst_mode     = 1'b0;
        long_hold_done = 1'b0;
        n_sent         = 0;
        n_checked      = 0;
        n_errors       = 0;
        n_div_faults   = 0;
        n_range_faults = 0;
        n_halts        = 0;
        rst_n          = 1'b0;

        // Directed part: an empty-stack fault, the literal extremes, negative
        // odd, the most negative word over minus one, unknown operators,
        // a halting jump, deep frame accesses at the largest offset,
        // a call and return, and a stack pushed to its very top.
        add_instr(OP_JPC, 0, 5);
        add_instr(OP_LIT, 0, 0);
        add_instr(OP_LIT, 3, 2047);
        add_instr(OP_OPR, 0, OPR_NEG);
        add_instr(OP_OPR, 0, OPR_ODD);
        add_instr(OP_OPR, 0, OPR_DIV);
        add_instr(OP_OPR, 0, 7);
        add_instr(OP_OPR, 0, 2047);
        add_instr(OP_LIT, 0, 1024);
        add_instr(OP_LIT, 0, 1024);
        add_instr(OP_OPR, 0, OPR_MUL);
        add_instr(OP_LIT, 0, 2048 / 2);
        add_instr(OP_OPR, 0, OPR_MUL);
        add_instr(OP_LIT, 0, 2);
        add_instr(OP_OPR, 0, OPR_MUL);
        add_instr(OP_LIT, 0, 1);
        add_instr(OP_OPR, 0, OPR_NEG);
        add_instr(OP_OPR, 0, OPR_DIV);
        add_instr(OP_LOD, 3, 2047);
        add_instr(OP_STO, 2, 4095 - 2048);
        add_instr(OP_CAL, 1, 2047);
        add_instr(OP_OPR, 0, OPR_RET);
        add_instr(OP_JMP, 0, 0);
        add_instr(OP_INT, 0, 2047);
        add_instr(OP_INT, 0, 2047);
        add_instr(OP_LIT, 0, 7);
        add_instr(OP_OPR, 0, OPR_RET, 1);

        // Random part, with the sender pausing halfway through.
        total = 0;
        while (total < 1200)
        begin
            total += add_random_sequence();
            if (total >= 600 && total < 610)
                program_q[$].sync = 1'b1;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (program_q.size() == 0 && !in_valid && state_q.size() == 0);
        repeat (100) @(posedge clk);

        $display("Executed %0d instructions and checked %0d results.", n_sent, n_checked);
        $display("Divide faults %0d, range faults %0d, halts %0d.",
                 n_div_faults, n_range_faults, n_halts);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: covers the stack clear after reset, long divides and every
    // stall, several times over.
    initial
    begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
